@@ rtl/core/asf_pkg.sv @@
// Shared types and constants for the ASF data packet parser.
package asf_pkg;

	localparam int StreamCount = 128;
	localparam int QueueDepth  = 4;
	localparam int QueueAw     = $clog2(QueueDepth);

	localparam logic [15:0] PacketSizeReset = 16'd4096;

	typedef enum logic [1:0] {
		CFG_PACKET_SIZE = 2'd0,
		CFG_PREROLL     = 2'd1,
		CFG_ENABLE_LOW  = 2'd2,
		CFG_ENABLE_HIGH = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic        status;
		logic [6:0]  stream;
		logic [31:0] obj;
		logic [31:0] offset;
		logic [31:0] ptime;
		logic        compressed;
		logic [5:0]  pidx;
		logic [7:0]  delta;
		logic [7:0]  data;
		logic        start;
		logic        last;
		logic [31:0] send;
		logic [15:0] dur;
	} job_t;

endpackage

@@ rtl/core/asf_front.sv @@
// Packet header parser: walks the byte stream and classifies payload bytes into jobs.
module asf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_ok,
	input  logic [7:0]                        data_byte,
	input  logic [15:0]                       packet_size,
	input  logic [asf_pkg::StreamCount-1:0]   stream_enable,
	output logic                              job_valid,
	output asf_pkg::job_t                     job
);

	typedef enum logic [20:0] {
		PH_FIRST   = 21'h000001,
		PH_EC      = 21'h000002,
		PH_FLAGS   = 21'h000004,
		PH_PROP    = 21'h000008,
		PH_PLEN    = 21'h000010,
		PH_SEQ     = 21'h000020,
		PH_PADL    = 21'h000040,
		PH_SEND    = 21'h000080,
		PH_DUR     = 21'h000100,
		PH_PCOUNT  = 21'h000200,
		PH_STREAM  = 21'h000400,
		PH_OBJ     = 21'h000800,
		PH_OFF     = 21'h001000,
		PH_REPLEN  = 21'h002000,
		PH_REP     = 21'h004000,
		PH_DELTA   = 21'h008000,
		PH_PAYLEN  = 21'h010000,
		PH_SUBLEN  = 21'h020000,
		PH_DATA    = 21'h040000,
		PH_SKIP    = 21'h080000,
		PH_PADDING = 21'h100000
	} phase_t;

	phase_t      phase_q;
	logic [15:0] bip_q;
	logic [2:0]  fbl_q;
	logic [31:0] acc_q, plen_q, padl_q, send_q, obj_q, off_q, repl_q, time_q, pl_q;
	logic [7:0]  flags_q, prop_q, delta_q, sub_q;
	logic [15:0] dur_q;
	logic [5:0]  total_q, pidx_q;
	logic [1:0]  lt_q;
	logic [6:0]  stream_q;
	logic        comp_q, firstp_q;

	phase_t      n_phase;
	logic [15:0] n_bip;
	logic [2:0]  n_fbl;
	logic [31:0] n_acc, n_plen, n_padl, n_send, n_obj, n_off, n_repl, n_time, n_pl;
	logic [7:0]  n_flags, n_prop, n_delta, n_sub;
	logic [15:0] n_dur;
	logic [5:0]  n_total, n_pidx;
	logic [1:0]  n_lt;
	logic [6:0]  n_stream;
	logic        n_comp, n_firstp;

	function automatic logic [2:0] code_width(input logic [1:0] c);
		return (c == 2'd3) ? 3'd4 : {1'b0, c};
	endfunction

	function automatic logic [2:0] width_of(input phase_t p, input logic [7:0] fl,
			input logic [7:0] pr, input logic [1:0] lt);
		logic [2:0] w;
		w = 3'd0;
		unique case (p)
			PH_PLEN:   w = code_width(fl[6:5]);
			PH_SEQ:    w = code_width(fl[2:1]);
			PH_PADL:   w = code_width(fl[4:3]);
			PH_SEND:   w = 3'd4;
			PH_DUR:    w = 3'd2;
			PH_OBJ:    w = code_width(pr[5:4]);
			PH_OFF:    w = code_width(pr[3:2]);
			PH_REPLEN: w = code_width(pr[1:0]);
			PH_PAYLEN: w = code_width(lt);
			default:   w = 3'd0;
		endcase
		return w;
	endfunction

	always_comb begin
		logic [16:0] bip_inc;
		logic [2:0]  w;
		logic [1:0]  sh;
		logic        fin_p, ent_p;
		phase_t      fp, ep;
		logic [31:0] fv;
		logic [32:0] used;
		n_phase = phase_q; n_bip = bip_q; n_fbl = fbl_q; n_acc = acc_q;
		n_plen = plen_q; n_padl = padl_q; n_send = send_q; n_obj = obj_q; n_off = off_q;
		n_repl = repl_q; n_time = time_q; n_pl = pl_q; n_flags = flags_q; n_prop = prop_q;
		n_delta = delta_q; n_sub = sub_q; n_dur = dur_q; n_total = total_q;
		n_pidx = pidx_q; n_lt = lt_q; n_stream = stream_q; n_comp = comp_q;
		n_firstp = firstp_q;
		job_valid = 1'b0;
		job = '0;
		fin_p = 1'b0; ent_p = 1'b0; fp = PH_FIRST; ep = PH_FIRST; fv = '0;
		w = '0; sh = '0; used = '0;
		bip_inc = {1'b0, bip_q} + 17'd1;
		n_bip = bip_inc[15:0];
		unique case (phase_q)
			PH_FIRST: begin
				if (data_byte[7]) begin
					if (data_byte[6:0] != 7'h02) begin
						job_valid = 1'b1;
						job.status = 1'b1;
						n_phase = PH_PADDING;
					end else begin
						n_fbl = 3'd2;
						n_phase = PH_EC;
					end
				end else begin
					n_flags = data_byte;
					n_phase = PH_PROP;
				end
			end
			PH_EC: begin
				if (fbl_q <= 3'd1) begin
					n_fbl = 3'd0;
					n_phase = PH_FLAGS;
				end else begin
					n_fbl = fbl_q - 3'd1;
				end
			end
			PH_FLAGS: begin
				n_flags = data_byte;
				n_phase = PH_PROP;
			end
			PH_PROP: begin
				n_prop = data_byte;
				ent_p = 1'b1; ep = PH_PLEN;
			end
			PH_PLEN, PH_SEQ, PH_PADL, PH_SEND, PH_DUR, PH_OBJ, PH_OFF, PH_REPLEN,
			PH_PAYLEN: begin
				w = width_of(phase_q, flags_q, prop_q, lt_q);
				sh = (w > fbl_q) ? 2'(w - fbl_q) : 2'd0;
				n_acc = acc_q | ({24'd0, data_byte} << {sh, 3'b000});
				if (fbl_q <= 3'd1) begin
					n_fbl = 3'd0;
					fin_p = 1'b1; fp = phase_q; fv = n_acc;
				end else begin
					n_fbl = fbl_q - 3'd1;
				end
			end
			PH_PCOUNT: begin
				n_total = data_byte[5:0];
				n_lt = data_byte[7:6];
				n_pidx = 6'd0;
				ent_p = 1'b1; ep = PH_STREAM;
			end
			PH_STREAM: begin
				n_stream = data_byte[6:0];
				ent_p = 1'b1; ep = PH_OBJ;
			end
			PH_REP: begin
				if (acc_q >= 32'd4 && acc_q < 32'd8)
					n_time = time_q | ({24'd0, data_byte} << {acc_q[1:0], 3'b000});
				n_acc = acc_q + 32'd1;
				if (repl_q <= 32'd1) begin
					n_repl = 32'd0;
					ent_p = 1'b1; ep = PH_PAYLEN;
				end else begin
					n_repl = repl_q - 32'd1;
				end
			end
			PH_DELTA: begin
				n_delta = data_byte;
				ent_p = 1'b1; ep = PH_PAYLEN;
			end
			PH_SUBLEN: begin
				n_sub = data_byte;
				if (pl_q != 32'd0)
					n_pl = pl_q - 32'd1;
				if (data_byte == 8'd0) begin
					ent_p = 1'b1;
					if (n_pl != 32'd0) begin
						ep = PH_SUBLEN;
					end else begin
						n_pidx = pidx_q + 6'd1;
						ep = PH_STREAM;
					end
				end else begin
					n_firstp = 1'b1;
					n_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				job_valid = 1'b1;
				job.stream = stream_q;
				job.obj = obj_q;
				job.offset = off_q;
				job.ptime = time_q;
				job.compressed = comp_q;
				job.pidx = pidx_q;
				job.delta = delta_q;
				job.data = data_byte;
				job.start = firstp_q && (off_q == 32'd0);
				job.send = send_q;
				job.dur = dur_q;
				n_firstp = 1'b0;
				if (comp_q) begin
					job.last = (sub_q <= 8'd1);
					if (pl_q != 32'd0)
						n_pl = pl_q - 32'd1;
					if (sub_q <= 8'd1) begin
						n_sub = 8'd0;
						ent_p = 1'b1;
						if (n_pl != 32'd0) begin
							ep = PH_SUBLEN;
						end else begin
							n_pidx = pidx_q + 6'd1;
							ep = PH_STREAM;
						end
					end else begin
						n_sub = sub_q - 8'd1;
					end
				end else begin
					job.last = (pl_q <= 32'd1);
					n_off = off_q + 32'd1;
					if (pl_q <= 32'd1) begin
						n_pl = 32'd0;
						n_pidx = pidx_q + 6'd1;
						ent_p = 1'b1; ep = PH_STREAM;
					end else begin
						n_pl = pl_q - 32'd1;
					end
				end
			end
			PH_SKIP: begin
				if (pl_q <= 32'd1) begin
					n_pl = 32'd0;
					n_pidx = pidx_q + 6'd1;
					ent_p = 1'b1; ep = PH_STREAM;
				end else begin
					n_pl = pl_q - 32'd1;
				end
			end
			default: ;
		endcase

		// header fields that close or are absent chain through here
		for (int k = 0; k < 8; k++) begin
			if (fin_p) begin
				fin_p = 1'b0;
				ent_p = 1'b1;
				unique case (fp)
					PH_PLEN: begin n_plen = fv; ep = PH_SEQ; end
					PH_SEQ:  ep = PH_PADL;
					PH_PADL: begin n_padl = fv; ep = PH_SEND; end
					PH_SEND: begin n_send = fv; ep = PH_DUR; end
					PH_DUR: begin
						n_dur = fv[15:0];
						if (n_flags[0]) begin
							ep = PH_PCOUNT;
						end else begin
							n_total = 6'd1;
							n_pidx = 6'd0;
							n_lt = 2'd2;
							ep = PH_STREAM;
						end
					end
					PH_OBJ: begin n_obj = fv; ep = PH_OFF; end
					PH_OFF: begin n_off = fv; ep = PH_REPLEN; end
					PH_REPLEN: begin
						n_delta = 8'd0;
						n_comp = 1'b0;
						if (fv > 32'd1) begin
							n_repl = fv;
							n_acc = 32'd0;
							n_time = 32'd0;
							ep = PH_REP;
						end else if (fv == 32'd1) begin
							n_comp = 1'b1;
							n_time = n_off;
							n_off = 32'd0;
							ep = PH_DELTA;
						end else begin
							n_time = n_send;
							ep = PH_PAYLEN;
						end
					end
					PH_PAYLEN: begin
						n_pl = fv;
						if (fv == 32'd0) begin
							n_pidx = n_pidx + 6'd1;
							ep = PH_STREAM;
						end else if (!stream_enable[n_stream]) begin
							ep = PH_SKIP;
						end else if (n_comp) begin
							ep = PH_SUBLEN;
						end else begin
							n_firstp = 1'b1;
							ep = PH_DATA;
						end
					end
					default: ep = PH_PADDING;
				endcase
			end
			if (ent_p) begin
				ent_p = 1'b0;
				n_phase = ep;
				unique case (ep)
					PH_PLEN, PH_SEQ, PH_PADL, PH_SEND, PH_DUR, PH_OBJ, PH_OFF, PH_REPLEN,
					PH_PAYLEN: begin
						if (ep == PH_PAYLEN && !n_flags[0]) begin
							used = {1'b0, n_padl} + {16'd0, bip_inc};
							fin_p = 1'b1; fp = ep;
							fv = ({1'b0, n_plen} > used) ? (n_plen - used[31:0]) : 32'd0;
						end else begin
							w = width_of(ep, n_flags, n_prop, n_lt);
							if (w != 3'd0) begin
								n_fbl = w;
								n_acc = 32'd0;
							end else begin
								fin_p = 1'b1; fp = ep;
								fv = (ep == PH_PLEN) ? {16'd0, packet_size} : 32'd0;
							end
						end
					end
					PH_STREAM: begin
						if (n_pidx >= n_total)
							n_phase = PH_PADDING;
					end
					default: ;
				endcase
			end
		end

		if (bip_inc >= {1'b0, packet_size}) begin
			n_bip = 16'd0;
			n_phase = PH_FIRST;
		end
		if (!byte_ok)
			job_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST; bip_q <= '0; fbl_q <= '0; acc_q <= '0;
			plen_q <= '0; padl_q <= '0; send_q <= '0; obj_q <= '0; off_q <= '0;
			repl_q <= '0; time_q <= '0; pl_q <= '0; flags_q <= '0; prop_q <= '0;
			delta_q <= '0; sub_q <= '0; dur_q <= '0; total_q <= '0; pidx_q <= '0;
			lt_q <= '0; stream_q <= '0; comp_q <= 1'b0; firstp_q <= 1'b0;
		end else if (byte_ok) begin
			phase_q <= n_phase; bip_q <= n_bip; fbl_q <= n_fbl; acc_q <= n_acc;
			plen_q <= n_plen; padl_q <= n_padl; send_q <= n_send; obj_q <= n_obj;
			off_q <= n_off; repl_q <= n_repl; time_q <= n_time; pl_q <= n_pl;
			flags_q <= n_flags; prop_q <= n_prop; delta_q <= n_delta; sub_q <= n_sub;
			dur_q <= n_dur; total_q <= n_total; pidx_q <= n_pidx; lt_q <= n_lt;
			stream_q <= n_stream; comp_q <= n_comp; firstp_q <= n_firstp;
		end
	end

endmodule

@@ rtl/core/asf_queue.sv @@
// Short job queue between the parser and the result stage.
module asf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  asf_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output asf_pkg::job_t head
);

	asf_pkg::job_t                  mem_q [asf_pkg::QueueDepth];
	logic [asf_pkg::QueueAw-1:0]    wr_q, rd_q;
	logic [asf_pkg::QueueAw:0]      cnt_q;

	assign full      = (cnt_q == (asf_pkg::QueueAw+1)'(asf_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/core/asf_back.sv @@
// Result stage: presentation time arithmetic and the output register.
module asf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  asf_pkg::job_t head,
	input  logic [31:0]   preroll_ms,
	input  logic          result_stall,
	output logic          pop,
	output logic          result_valid,
	output logic          status,
	output logic [6:0]    stream_id,
	output logic [31:0]   media_object,
	output logic [31:0]   object_offset,
	output logic [31:0]   presentation_ms,
	output logic [7:0]    payload_byte,
	output logic          object_start,
	output logic          last_of_payload,
	output logic [31:0]   send_time,
	output logic [15:0]   packet_duration
);

	logic        valid_q;
	logic [31:0] diff;
	logic [13:0] prod;
	logic [32:0] sum;
	logic [31:0] pres;

	assign pop = head_valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;

	always_comb begin
		diff = (head.ptime > preroll_ms) ? (head.ptime - preroll_ms) : 32'd0;
		prod = head.compressed ? ({8'd0, head.pidx} * {6'd0, head.delta}) : 14'd0;
		sum  = {1'b0, diff} + {19'd0, prod};
		pres = sum[32] ? 32'hffff_ffff : sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !result_stall)
			valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status          <= head.status;
			stream_id       <= head.stream;
			media_object    <= head.obj;
			object_offset   <= head.offset;
			presentation_ms <= pres;
			payload_byte    <= head.data;
			object_start    <= head.start;
			last_of_payload <= head.last;
			send_time       <= head.send;
			packet_duration <= head.dur;
		end
	end

endmodule

@@ rtl/core/asf_data_packet_parser_unit.sv @@
// Top level of the ASF data packet parser: configuration registers and block wiring.
//
// Byte channel: data_byte with byte_valid/byte_stall; one byte is a beat when
// valid is high and stall is low. Result channel: one beat per forwarded payload
// byte or per rejected packet header, with result_valid/result_stall.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// Throughput: one byte per cycle while byte_stall is low. The parser resolves a whole header step,
// including absent fields, in the cycle the byte arrives.
// Path: a result is registered first in the job queue (parser into the job
// queue), then in the output register (result stage into the output register).
// The four-entry job queue decouples parser and result stage; when the receiver
// stalls, the output register holds, the queue fills and then byte_stall rises.
// Reset: parser waits for the first byte of a packet, queue and output are
// empty, packet size is 4096, preroll and stream enables are zero.
module asf_data_packet_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        status,
	output logic [6:0]  stream_id,
	output logic [31:0] media_object,
	output logic [31:0] object_offset,
	output logic [31:0] presentation_ms,
	output logic [7:0]  payload_byte,
	output logic        object_start,
	output logic        last_of_payload,
	output logic [31:0] send_time,
	output logic [15:0] packet_duration
);

	logic [15:0]   packet_size_q;
	logic [31:0]   preroll_q;
	logic [63:0]   en_low_q, en_high_q;
	logic          full, not_empty, pop, job_valid;
	asf_pkg::job_t job, head;

	assign cfg_ready  = 1'b1;
	assign byte_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_size_q <= asf_pkg::PacketSizeReset;
			preroll_q     <= '0;
			en_low_q      <= '0;
			en_high_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (asf_pkg::cfg_index_t'(cfg_index))
				asf_pkg::CFG_PACKET_SIZE: packet_size_q <= cfg_data[15:0];
				asf_pkg::CFG_PREROLL:     preroll_q     <= cfg_data[31:0];
				asf_pkg::CFG_ENABLE_LOW:  en_low_q      <= cfg_data;
				asf_pkg::CFG_ENABLE_HIGH: en_high_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	asf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_ok       (byte_valid && !byte_stall),
		.data_byte     (data_byte),
		.packet_size   (packet_size_q),
		.stream_enable ({en_high_q, en_low_q}),
		.job_valid     (job_valid),
		.job           (job)
	);

	asf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_job  (job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	asf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (not_empty),
		.head            (head),
		.preroll_ms      (preroll_q),
		.result_stall    (result_stall),
		.pop             (pop),
		.result_valid    (result_valid),
		.status          (status),
		.stream_id       (stream_id),
		.media_object    (media_object),
		.object_offset   (object_offset),
		.presentation_ms (presentation_ms),
		.payload_byte    (payload_byte),
		.object_start    (object_start),
		.last_of_payload (last_of_payload),
		.send_time       (send_time),
		.packet_duration (packet_duration)
	);

endmodule

@@ rtl/core/asf_checker.sv @@
// Port-level assertions for the ASF data packet parser, bound to the top level.
module asf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        result_valid,
	input logic        result_stall,
	input logic        status,
	input logic [6:0]  stream_id,
	input logic [31:0] object_offset,
	input logic [31:0] presentation_ms,
	input logic [7:0]  payload_byte,
	input logic        object_start
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(payload_byte))
		else $error("stalled result beat changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> stream_id == 7'd0 && payload_byte == 8'd0
			&& presentation_ms == 32'd0 && !object_start)
		else $error("error beat carries payload data");

	a_start_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && object_start |-> object_offset == 32'd0)
		else $error("object start with nonzero offset");

	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind asf_data_packet_parser_unit asf_checker u_asf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cfg_ready       (cfg_ready),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.status          (status),
	.stream_id       (stream_id),
	.object_offset   (object_offset),
	.presentation_ms (presentation_ms),
	.payload_byte    (payload_byte),
	.object_start    (object_start)
);

@@ dv/asf_parser_checker.sv @@
// Checker for the ASF packet parser: predicts each result beat from accepted bytes and compares.
`timescale 1ns / 100ps
module asf_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        status,
	input  logic [6:0]  stream_id,
	input  logic [31:0] media_object,
	input  logic [31:0] object_offset,
	input  logic [31:0] presentation_ms,
	input  logic [7:0]  payload_byte,
	input  logic        object_start,
	input  logic        last_of_payload,
	input  logic [31:0] send_time,
	input  logic [15:0] packet_duration,
	input  logic        at_end,
	output int          fails,
	output int          pending,
	output int          bytes_in,
	output int          beats_out,
	output int          header_errs
);

	typedef enum logic [4:0] {
		P_FIRST, P_EC, P_FLAGS, P_PROP, P_PLEN, P_SEQ, P_PADL, P_SEND, P_DUR, P_PCOUNT,
		P_STREAM, P_OBJ, P_OFF, P_REPLEN, P_REP, P_DELTA, P_PAYLEN, P_SUBLEN, P_DATA,
		P_SKIP, P_PADDING
	} phase_t;

	typedef struct packed {
		logic        status;
		logic [6:0]  stream;
		logic [31:0] obj;
		logic [31:0] offset;
		logic [31:0] ptime;
		logic [7:0]  data;
		logic        start;
		logic        last;
		logic [31:0] send;
		logic [15:0] dur;
	} parsed_t;

	logic [15:0] pk_size;
	logic [31:0] preroll;
	logic [63:0] en_lo, en_hi;

	phase_t      ph;
	logic [31:0] bip, acc, plen, padl, sendt, ptotal, pidx, ltype, strm, obj, offs;
	logic [31:0] repl, ctime, delta, payl, subl;
	logic [7:0]  flg, prop;
	logic [15:0] dur;
	int          fleft;
	logic        comp, firstp;

	parsed_t     expq[$];
	int          mism;

	assign fails = mism + (at_end ? pending : 0);

	function automatic int code_w(logic [7:0] c);
		return c[1:0] == 2'd3 ? 4 : int'(c[1:0]);
	endfunction

	function automatic bit is_fld(phase_t p);
		return (p >= P_PLEN && p <= P_DUR) || (p >= P_OBJ && p <= P_REPLEN) || p == P_PAYLEN;
	endfunction

	function automatic int fld_width(phase_t p);
		case (p)
			P_PLEN:   return code_w(flg >> 5);
			P_SEQ:    return code_w(flg >> 1);
			P_PADL:   return code_w(flg >> 3);
			P_SEND:   return 4;
			P_DUR:    return 2;
			P_OBJ:    return code_w(prop >> 4);
			P_OFF:    return code_w(prop >> 2);
			P_REPLEN: return code_w(prop);
			P_PAYLEN: return code_w(ltype[7:0]);
			default:  return 0;
		endcase
	endfunction

	function automatic bit strm_on();
		logic [6:0] s;
		s = strm[6:0];
		return s < 64 ? en_lo[s[5:0]] : en_hi[s[5:0]];
	endfunction

	function automatic phase_t next_pl();
		pidx = (pidx + 1) & 32'h3f;
		return P_STREAM;
	endfunction

	function automatic phase_t start_body();
		if (payl == 0) return next_pl();
		if (!strm_on()) return P_SKIP;
		if (comp) return P_SUBLEN;
		firstp = 1'b1;
		return P_DATA;
	endfunction

	function automatic phase_t finish_fld(phase_t p, logic [31:0] v);
		case (p)
			P_PLEN: begin plen = v; return P_SEQ; end
			P_SEQ:  return P_PADL;
			P_PADL: begin padl = v; return P_SEND; end
			P_SEND: begin sendt = v; return P_DUR; end
			P_DUR: begin
				dur = v[15:0];
				if (flg[0]) return P_PCOUNT;
				ptotal = 1;
				pidx = 0;
				ltype = 2;
				return P_STREAM;
			end
			P_OBJ: begin obj = v; return P_OFF; end
			P_OFF: begin offs = v; return P_REPLEN; end
			P_REPLEN: begin
				delta = 0;
				comp = 1'b0;
				if (v > 1) begin
					repl = v;
					acc = 0;
					ctime = 0;
					return P_REP;
				end
				if (v == 1) begin
					comp = 1'b1;
					ctime = offs;
					offs = 0;
					return P_DELTA;
				end
				ctime = sendt;
				return P_PAYLEN;
			end
			P_PAYLEN: begin
				payl = v;
				return start_body();
			end
			default: return P_PADDING;
		endcase
	endfunction

	function automatic void enter_ph(phase_t p);
		int w;
		longint unsigned used;
		while (1) begin
			ph = p;
			if (is_fld(p)) begin
				if (p == P_PAYLEN && !flg[0]) begin
					used = longint'(padl) + longint'(bip);
					p = finish_fld(p, longint'(plen) > used ? 32'(longint'(plen) - used) : 32'd0);
					continue;
				end
				w = fld_width(p);
				if (w != 0) begin
					fleft = w;
					acc = 0;
					return;
				end
				p = finish_fld(p, p == P_PLEN ? 32'(pk_size) : 32'd0);
				continue;
			end
			if (p == P_STREAM && pidx >= ptotal) ph = P_PADDING;
			return;
		end
	endfunction

	function automatic parsed_t data_beat(logic [7:0] b, bit lst);
		parsed_t r;
		longint unsigned t;
		t = ctime > preroll ? longint'(ctime - preroll) : 0;
		if (comp) t += longint'(pidx) * longint'(delta);
		if (t > 64'hffffffff) t = 64'hffffffff;
		r.status = 1'b0;
		r.stream = strm[6:0];
		r.obj    = obj;
		r.offset = offs;
		r.ptime  = t[31:0];
		r.data   = b;
		r.start  = firstp && offs == 0;
		r.last   = lst;
		r.send   = sendt;
		r.dur    = dur;
		firstp = 1'b0;
		return r;
	endfunction

	function automatic void parse_byte(logic [7:0] b, output bit hit, output parsed_t r);
		int w, left, idx;
		hit = 1'b0;
		r = '0;
		bip = (bip + 1) & 32'h1ffff;
		case (ph)
			P_FIRST: begin
				if (b[7]) begin
					if (b[6:0] != 7'h02) begin
						r.status = 1'b1;
						hit = 1'b1;
						ph = P_PADDING;
					end else begin
						fleft = 2;
						ph = P_EC;
					end
				end else begin
					flg = b;
					ph = P_PROP;
				end
			end
			P_EC: begin
				if (fleft <= 1) begin
					fleft = 0;
					ph = P_FLAGS;
				end else fleft--;
			end
			P_FLAGS: begin
				flg = b;
				ph = P_PROP;
			end
			P_PROP: begin
				prop = b;
				enter_ph(P_PLEN);
			end
			P_PLEN, P_SEQ, P_PADL, P_SEND, P_DUR, P_OBJ, P_OFF, P_REPLEN, P_PAYLEN: begin
				w = fld_width(ph);
				left = fleft;
				idx = (w > left ? w - left : 0) & 3;
				acc |= 32'(b) << (8 * idx);
				if (left <= 1) begin
					fleft = 0;
					enter_ph(finish_fld(ph, acc));
				end else fleft = left - 1;
			end
			P_PCOUNT: begin
				ptotal = 32'(b & 8'h3f);
				ltype = 32'(b >> 6);
				pidx = 0;
				enter_ph(P_STREAM);
			end
			P_STREAM: begin
				strm = 32'(b & 8'h7f);
				enter_ph(P_OBJ);
			end
			P_REP: begin
				if (acc >= 4 && acc < 8) ctime |= 32'(b) << (8 * (acc - 4));
				acc++;
				if (repl <= 1) begin
					repl = 0;
					enter_ph(P_PAYLEN);
				end else repl--;
			end
			P_DELTA: begin
				delta = 32'(b);
				enter_ph(P_PAYLEN);
			end
			P_SUBLEN: begin
				subl = 32'(b);
				if (payl > 0) payl--;
				if (b == 0) enter_ph(payl != 0 ? P_SUBLEN : next_pl());
				else begin
					firstp = 1'b1;
					ph = P_DATA;
				end
			end
			P_DATA: begin
				hit = 1'b1;
				if (comp) begin
					r = data_beat(b, subl <= 1);
					if (payl > 0) payl--;
					if (subl <= 1) begin
						subl = 0;
						enter_ph(payl != 0 ? P_SUBLEN : next_pl());
					end else subl--;
				end else begin
					r = data_beat(b, payl <= 1);
					offs++;
					if (payl <= 1) begin
						payl = 0;
						enter_ph(next_pl());
					end else payl--;
				end
			end
			P_SKIP: begin
				if (payl <= 1) begin
					payl = 0;
					enter_ph(next_pl());
				end else payl--;
			end
			default: ;
		endcase
		if (bip >= 32'(pk_size)) begin
			bip = 0;
			ph = P_FIRST;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parsed_t e, a;
		bit hit;
		if (!arst_n) begin
			pk_size = asf_pkg::PacketSizeReset;
			preroll = 0; en_lo = 0; en_hi = 0;
			ph = P_FIRST;
			bip = 0; acc = 0; plen = 0; padl = 0; sendt = 0; ptotal = 0; pidx = 0;
			ltype = 0; strm = 0; obj = 0; offs = 0; repl = 0; ctime = 0; delta = 0;
			payl = 0; subl = 0; flg = 0; prop = 0; dur = 0; fleft = 0;
			comp = 1'b0; firstp = 1'b0;
			expq.delete();
			mism = 0; pending = 0; bytes_in = 0; beats_out = 0; header_errs = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (asf_pkg::cfg_index_t'(cfg_index))
					asf_pkg::CFG_PACKET_SIZE: pk_size = cfg_data[15:0];
					asf_pkg::CFG_PREROLL:     preroll = cfg_data[31:0];
					asf_pkg::CFG_ENABLE_LOW:  en_lo = cfg_data;
					asf_pkg::CFG_ENABLE_HIGH: en_hi = cfg_data;
				endcase
			end
			if (byte_valid && !byte_stall) begin
				bytes_in++;
				parse_byte(data_byte, hit, e);
				if (hit) expq.push_back(e);
			end
			if (result_valid && !result_stall) begin
				a = '{status, stream_id, media_object, object_offset,
					presentation_ms, payload_byte, object_start, last_of_payload,
					send_time, packet_duration};
				beats_out++;
				if (status) header_errs++;
				if (expq.size() == 0) begin
					mism++;
					if (mism <= 10) $display("%t unexpected result beat %h", $time, a);
				end else begin
					e = expq.pop_front();
					if (a !== e) begin
						mism++;
						if (mism <= 10)
							$display("%t mismatch: expected %h actual %h", $time, e, a);
					end
				end
			end
			pending = expq.size();
		end
	end

endmodule

@@ dv/tb_asf_data_packet_parser_unit.sv @@
// Testbench top for the ASF packet parser: builds packet streams, drives handshakes, reports.
`timescale 1ns / 100ps
module tb_asf_data_packet_parser_unit;

	logic        clk, arst_n;
	logic        byte_valid, byte_stall;
	logic [7:0]  data_byte;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        result_valid, result_stall;
	logic        status, object_start, last_of_payload;
	logic [6:0]  stream_id;
	logic [31:0] media_object, object_offset, presentation_ms, send_time;
	logic [7:0]  payload_byte;
	logic [15:0] packet_duration;
	logic        at_end;
	int          fails, pending, bytes_in, beats_out, header_errs;

	int          tx_pct, rx_pct, hold_cnt, wd, settings;
	bit          hold_kick, hold_seen;
	logic [7:0]  pkt[$];

	localparam int WdLimit = 5000;

	asf_data_packet_parser_unit dut (.*);

	asf_parser_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_cnt <= 300;
			result_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			result_stall <= 1'b1;
		end else result_stall <= ($urandom_range(99) < rx_pct);
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready) || !arst_n) wd <= 0;
		else wd <= wd + 1;
		if (wd >= WdLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] b);
		bit st;
		while ($urandom_range(99) < tx_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		do begin
			@(negedge clk);
			st = byte_stall;
			@(posedge clk);
		end while (st);
	endtask

	task automatic cfg_put(input asf_pkg::cfg_index_t idx, input logic [63:0] v);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic set_all(input logic [15:0] sz, input logic [31:0] pre,
			input logic [63:0] lo, input logic [63:0] hi);
		cfg_put(asf_pkg::CFG_PACKET_SIZE, 64'(sz));
		cfg_put(asf_pkg::CFG_PREROLL, 64'(pre));
		cfg_put(asf_pkg::CFG_ENABLE_LOW, lo);
		cfg_put(asf_pkg::CFG_ENABLE_HIGH, hi);
		cfg_valid <= 1'b0;
		settings++;
		@(posedge clk);
	endtask

	task automatic drain();
		int n;
		byte_valid <= 1'b0;
		n = 0;
		while (pending != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] trunc_fld(logic [31:0] v, logic [1:0] c);
		case (c)
			2'd0: return 0;
			2'd1: return v & 32'hff;
			2'd2: return v & 32'hffff;
			default: return v;
		endcase
	endfunction

	function automatic void push_fld(logic [31:0] v, logic [1:0] c);
		int w;
		w = c == 2'd3 ? 4 : int'(c);
		for (int i = 0; i < w; i++) pkt.push_back(v[8*i +: 8]);
	endfunction

	function automatic logic [7:0] pick_stream();
		logic [7:0] s;
		case ($urandom_range(3))
			0: s = 8'($urandom_range(0, 1));
			1: s = $urandom_range(1) ? 8'd63 : 8'd64;
			2: s = 8'd127;
			default: s = 8'($urandom_range(127));
		endcase
		s[7] = 1'($urandom_range(1));
		return s;
	endfunction

	// One packet of exactly sz bytes; well-formed most of the time, content random.
	function automatic void make_packet(int sz);
		int r, n, rem, s;
		logic [7:0] flg, prop, b;
		logic [1:0] lt;
		logic [31:0] v, ln;
		pkt.delete();
		r = $urandom_range(99);
		if (r >= 6 && r < 12) begin
			b = 8'h80 | 8'($urandom_range(127));
			if (b == 8'h82) b = 8'h83;
			pkt.push_back(b);
		end else if (r >= 12) begin
			flg = 8'($urandom);
			if ($urandom_range(99) < 60) begin
				pkt.push_back(8'h82);
				pkt.push_back(8'($urandom));
				pkt.push_back(8'($urandom));
			end else flg[7] = 1'b0;
			prop = 8'($urandom);
			pkt.push_back(flg);
			pkt.push_back(prop);
			push_fld($urandom_range(3) == 0 ? $urandom : sz - $urandom_range(0, 8), flg[6:5]);
			push_fld($urandom, flg[2:1]);
			push_fld($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 6), flg[4:3]);
			push_fld($urandom, 2'd3);
			push_fld($urandom, 2'd2);
			lt = 2'd2;
			n = 1;
			if (flg[0]) begin
				n = $urandom_range(15) == 0 ? 63 : $urandom_range(0, 4);
				lt = $urandom_range(7) == 0 ? 2'd0 : 2'($urandom_range(1, 3));
				pkt.push_back({lt, 6'(n)});
			end
			for (int p = 0; p < n && pkt.size() < sz; p++) begin
				pkt.push_back(pick_stream());
				push_fld($urandom, prop[5:4]);
				push_fld($urandom_range(1) ? 32'd0 : $urandom, prop[3:2]);
				case ($urandom_range(3))
					0: v = 0;
					1: v = 1;
					2: v = 8;
					default: v = $urandom_range(2, 10);
				endcase
				push_fld(v, prop[1:0]);
				v = trunc_fld(v, prop[1:0]);
				if (v == 1) pkt.push_back(8'($urandom));
				else for (int i = 0; i < v && i < 16; i++) pkt.push_back(8'($urandom));
				if (!flg[0]) break;
				push_fld($urandom_range(0, 12), lt);
				ln = trunc_fld($urandom_range(0, 12), lt);
				ln = pkt.size() > 0 ? ln : 0;
				if (v == 1) begin
					rem = ln;
					while (rem > 0) begin
						s = $urandom_range(0, 5);
						pkt.push_back(8'(s));
						for (int i = 0; i < s; i++) pkt.push_back(8'($urandom));
						rem -= s + 1;
					end
				end else for (int i = 0; i < ln; i++) pkt.push_back(8'($urandom));
			end
		end
		while (pkt.size() < sz) pkt.push_back(8'($urandom));
		while (pkt.size() > sz) void'(pkt.pop_back());
	endfunction

	task automatic run_phase(int sz, int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			make_packet(sz);
			foreach (pkt[i]) put_byte(pkt[i]);
			sent += sz;
		end
	endtask

	initial begin
		logic [7:0] dir[$];
		int sz;
		logic [31:0] pre;
		logic [63:0] lo, hi;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		result_stall = 1'b0;
		at_end = 1'b0;
		tx_pct = 0;
		rx_pct = 0;
		hold_cnt = 0;
		hold_kick = 1'b0;
		hold_seen = 1'b0;
		settings = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single payload from a 16-byte packet, time taken from the send time less the preroll,
		// then a rejected error-correction header
		set_all(16'd16, 32'd100, '1, '1);
		dir = '{8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h34, 8'h12, 8'h81, 8'haa, 8'hbb, 8'hcc, 8'hdd,
			8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		foreach (dir[i]) put_byte(dir[i]);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			tx_pct = ph < 3 ? 24 : ph < 6 ? 58 : 0;
			rx_pct = ph < 3 ? 58 : ph < 6 ? 24 : 0;
			sz = ph == 0 ? 16 : ph == 4 ? 65535 : $urandom_range(20, 90);
			pre = ph == 1 ? 32'd0 : ph == 2 ? 32'hffffffff : $urandom;
			lo = ph == 0 ? '1 : ph == 3 ? '0 : {$urandom, $urandom} | {$urandom, $urandom};
			hi = ph == 0 ? '1 : ph == 3 ? '0 : {$urandom, $urandom} | {$urandom, $urandom};
			set_all(16'(sz), pre, lo, hi);
			if (ph == 6) hold_kick <= ~hold_kick;
			if (ph == 4) run_phase(80, 80);
			else run_phase(sz, 150);
			drain();
		end

		at_end <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Parsed %0d bytes over %0d settings, packet sizes 16 to 65535.", bytes_in,
			settings);
		$display("Checked %0d result beats, %0d of them rejected headers.", beats_out,
			header_errs);
		if (fails == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
